// ----- design/obb_pkg.sv -----
`default_nettype none
package obb_pkg;

    typedef logic signed [63:0] t_s64;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LDC, ST_LDD, ST_AXL, ST_DOT, ST_HLD, ST_ALD, ST_SVM,
        ST_SVD, ST_CMP, ST_SCA, ST_SCB, ST_CRA, ST_CRB, ST_CRM, ST_DONE
    } t_state;

    localparam int          NUM_VEC     = 10;
    localparam int          VEC_W       = 96;
    localparam logic [3:0]  VEC_PER_BOX = 4'd5;
    localparam logic [2:0]  SLOT_CENTER = 3'd0;
    localparam logic [2:0]  SLOT_HALF   = 3'd4;
    localparam logic [3:0]  AXIS_NONE   = 4'd15;
    localparam logic [3:0]  AXIS_FACE_LAST  = 4'd5;
    localparam logic [3:0]  AXIS_CROSS_FIRST = 4'd6;
    localparam logic [3:0]  AXIS_LAST   = 4'd14;

    localparam t_s64 S64_MAX = {1'b0, {63{1'b1}}};
    localparam t_s64 S64_MIN = {1'b1, {63{1'b0}}};

    function automatic t_s64 sat_add(input t_s64 a, input t_s64 b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? S64_MIN : S64_MAX;
        end
        return s[63:0];
    endfunction

    function automatic t_s64 sat_sub(input t_s64 a, input t_s64 b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? S64_MIN : S64_MAX;
        end
        return s[63:0];
    endfunction

    function automatic t_s64 sat_abs(input t_s64 a);
        if (a == S64_MIN) begin
            return S64_MAX;
        end
        return a[63] ? -a : a;
    endfunction

endpackage
`default_nettype wire

// ----- design/obb_if.sv -----
`default_nettype none
interface obb_in_if;
    logic               valid;
    logic               ready;
    logic               box_index;
    logic [2:0]         slot_index;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               evaluate;

    modport source (output valid, box_index, slot_index, x, y, z, evaluate,
                    input ready);
    modport sink   (input valid, box_index, slot_index, x, y, z, evaluate,
                    output ready);
endinterface

interface obb_out_if;
    logic       valid;
    logic       ready;
    logic       overlap;
    logic [3:0] separating_axis;
    logic       parallel_shortcut;

    modport source (output valid, overlap, separating_axis, parallel_shortcut,
                    input ready);
    modport sink   (input valid, overlap, separating_axis, parallel_shortcut,
                    output ready);
endinterface
`default_nettype wire

// ----- design/obb_obb_separating_axis_test.sv -----
`default_nettype none
// Channel   | Dir | Payload                                        | Handshake
// i_in      | in  | box_index, slot_index, x, y, z, evaluate       | valid/ready
// o_res     | out | overlap, separating_axis, parallel_shortcut    | valid/ready
//
// A transaction with evaluate set stores its vector, then runs the test on one
// shared 64x64 saturating multiplier (start, four 32x32 partial products,
// negate, shift/saturate). Each store read has an address step and a
// registered data step. A face axis takes 39 products, a cross axis 45
// products, for up to fifteen axes. i_in.ready is low while the test runs.
// Synchronous active-low reset clears the vector store, the state, the
// multiplier phase and the handshake flags. The result sits in an output
// register; loads are taken while it waits, and a finished test holds in its
// last state until it is free.
module obb_obb_separating_axis_test #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    obb_in_if.sink     i_in,
    obb_out_if.source  o_res
);
    import obb_pkg::*;

    // stored words are read as signed values of this many bits
    localparam int IN_W = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

    function automatic t_s64 ext(input logic [31:0] w);
        return {{(64-IN_W){w[IN_W-1]}}, w[IN_W-1:0]};
    endfunction

    t_state r_state;
    t_state n_state;

    // sequencer counters
    logic [3:0] r_ax;      // test-order axis index
    logic [1:0] r_i;       // axis of box A
    logic [1:0] r_j;       // axis of box B
    logic [1:0] r_k;       // axis inside the radius sum
    logic       r_bx;      // box inside the radius sum
    logic [2:0] r_c;       // product counter inside a state
    logic       r_wait;    // product in flight
    logic       r_rd;      // store read issued, data valid this cycle
    logic       r_sep;
    logic       r_short;

    // datapath
    t_s64 r_d  [3];
    t_s64 r_l  [3];
    t_s64 r_va [3];
    t_s64 r_vb [3];
    t_s64 r_vh [3];
    t_s64 r_sv [3];
    t_s64 r_tmp;
    t_s64 r_acc;
    t_s64 r_dist;
    t_s64 r_r;

    // result register
    logic       r_ovalid;
    logic       r_overlap;
    logic [3:0] r_axis;
    logic       r_pshort;

    logic        in_acc;
    logic        we;
    logic [3:0]  waddr;
    logic [3:0]  raddr;
    logic [95:0] rdata;
    t_s64        rv [3];
    logic        eq;
    logic        ld_state;
    logic        mul_start;
    logic        mul_done;
    t_s64        mul_a;
    t_s64        mul_b;
    t_s64        mul_p;
    t_s64        acc_nx;
    logic        c_last3;
    logic        c_last6;
    logic        out_free;

    assign in_acc   = i_in.valid & i_in.ready;
    assign we       = in_acc && (i_in.slot_index <= SLOT_HALF);
    assign waddr    = (i_in.box_index ? VEC_PER_BOX : 4'd0) + 4'(i_in.slot_index);
    assign out_free = !r_ovalid || o_res.ready;

    obb_vec_store #(.WIDTH(VEC_W), .DEPTH(NUM_VEC)) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata ({i_in.z, i_in.y, i_in.x}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    obb_sat_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    always_comb begin
        for (int n = 0; n < 3; n++) begin
            rv[n] = ext(rdata[32*n +: 32]);
        end
    end

    // every load state issues the address, then takes the registered data
    assign ld_state = r_state inside {ST_LDC, ST_LDD, ST_AXL, ST_HLD, ST_ALD,
                                      ST_SCA, ST_SCB, ST_CRA, ST_CRB};

    assign eq      = (rv[0] == r_va[0]) && (rv[1] == r_va[1]) && (rv[2] == r_va[2]);
    assign acc_nx  = sat_add(r_acc, mul_p);
    assign c_last3 = (r_c == 3'd2);
    assign c_last6 = (r_c == 3'd5);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_acc && i_in.evaluate) n_state = ST_LDC;
            ST_LDC:  if (r_rd) n_state = ST_LDD;
            ST_LDD:  if (r_rd) n_state = ST_AXL;
            ST_AXL:  if (r_rd) n_state = ST_DOT;
            ST_DOT:  if (mul_done && c_last3) n_state = ST_HLD;
            ST_HLD:  if (r_rd) n_state = ST_ALD;
            ST_ALD:  if (r_rd) n_state = ST_SVM;
            ST_SVM:  if (mul_done && c_last3) n_state = ST_SVD;
            ST_SVD: begin
                if (mul_done && c_last3) begin
                    if (r_k != 2'd2) n_state = ST_ALD;
                    else if (!r_bx)  n_state = ST_HLD;
                    else             n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (r_dist > r_r)                n_state = ST_DONE;
                else if (r_ax < AXIS_FACE_LAST)  n_state = ST_AXL;
                else if (r_ax == AXIS_FACE_LAST) n_state = ST_SCA;
                else if (r_ax == AXIS_LAST)      n_state = ST_DONE;
                else                             n_state = ST_CRA;
            end
            ST_SCA:  if (r_rd) n_state = ST_SCB;
            ST_SCB: begin
                if (r_rd && r_j == 2'd2) begin
                    if (r_i != 2'd2)      n_state = ST_SCA;
                    else if (r_short || eq) n_state = ST_DONE;
                    else                  n_state = ST_CRA;
                end
            end
            ST_CRA:  if (r_rd) n_state = ST_CRB;
            ST_CRB:  if (r_rd) n_state = ST_CRM;
            ST_CRM:  if (mul_done && c_last6) n_state = ST_DOT;
            ST_DONE: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: store address, multiplier start and multiplier operands
    always_comb begin
        raddr     = 4'd0;
        mul_start = 1'b0;
        mul_a     = r_d[r_c[1:0]];
        mul_b     = r_l[r_c[1:0]];
        unique case (r_state) inside
            ST_LDC: raddr = 4'(SLOT_CENTER);
            ST_LDD: raddr = VEC_PER_BOX + 4'(SLOT_CENTER);
            ST_AXL: raddr = (r_ax[0] ? VEC_PER_BOX : 4'd0) + 4'd1 + 4'(r_ax[2:1]);
            ST_HLD: raddr = (r_bx ? VEC_PER_BOX : 4'd0) + 4'(SLOT_HALF);
            ST_ALD: raddr = (r_bx ? VEC_PER_BOX : 4'd0) + 4'd1 + 4'(r_k);
            ST_SCA, ST_CRA: raddr = 4'd1 + 4'(r_i);
            ST_SCB, ST_CRB: raddr = VEC_PER_BOX + 4'd1 + 4'(r_j);
            ST_DOT: mul_start = !r_wait;
            ST_SVM: begin
                mul_start = !r_wait;
                mul_a     = r_va[r_c[1:0]];
                mul_b     = r_vh[r_k];
            end
            ST_SVD: begin
                mul_start = !r_wait;
                mul_a     = r_sv[r_c[1:0]];
            end
            ST_CRM: begin
                mul_start = !r_wait;
                case (r_c)
                    3'd0:    begin mul_a = r_va[1]; mul_b = r_vb[2]; end
                    3'd1:    begin mul_a = r_va[2]; mul_b = r_vb[1]; end
                    3'd2:    begin mul_a = r_va[2]; mul_b = r_vb[0]; end
                    3'd3:    begin mul_a = r_va[0]; mul_b = r_vb[2]; end
                    3'd4:    begin mul_a = r_va[0]; mul_b = r_vb[1]; end
                    default: begin mul_a = r_va[1]; mul_b = r_vb[0]; end
                endcase
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_wait   <= 1'b0;
            r_rd     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd    <= ld_state && !r_rd;
            if (mul_start)     r_wait <= 1'b1;
            else if (mul_done) r_wait <= 1'b0;
            if (r_state == ST_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath and counters
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_LDC: begin
                if (r_rd) begin
                    r_va    <= rv;
                    r_sep   <= 1'b0;
                    r_short <= 1'b0;
                end
            end
            ST_LDD: begin
                if (r_rd) begin
                    for (int n = 0; n < 3; n++) begin
                        r_d[n] <= rv[n] - r_va[n];
                    end
                    r_ax <= 4'd0;
                end
            end
            ST_AXL: begin
                if (r_rd) begin
                    r_l   <= rv;
                    r_c   <= 3'd0;
                    r_acc <= '0;
                end
            end
            ST_DOT: begin
                if (mul_done) begin
                    r_acc <= acc_nx;
                    if (c_last3) begin
                        r_dist <= sat_abs(acc_nx);
                        r_r    <= '0;
                        r_bx   <= 1'b0;
                        r_k    <= 2'd0;
                        r_c    <= 3'd0;
                    end else begin
                        r_c <= r_c + 3'd1;
                    end
                end
            end
            ST_HLD: if (r_rd) r_vh <= rv;
            ST_ALD: begin
                if (r_rd) begin
                    r_va <= rv;
                    r_c  <= 3'd0;
                end
            end
            ST_SVM: begin
                if (mul_done) begin
                    r_sv[r_c[1:0]] <= mul_p;
                    if (c_last3) begin
                        r_c   <= 3'd0;
                        r_acc <= '0;
                    end else begin
                        r_c <= r_c + 3'd1;
                    end
                end
            end
            ST_SVD: begin
                if (mul_done) begin
                    r_acc <= acc_nx;
                    if (c_last3) begin
                        // all terms are magnitudes: one running sum serves both boxes
                        r_r <= sat_add(r_r, sat_abs(acc_nx));
                        r_c <= 3'd0;
                        if (r_k == 2'd2) begin
                            r_k  <= 2'd0;
                            r_bx <= 1'b1;
                        end else begin
                            r_k <= r_k + 2'd1;
                        end
                    end else begin
                        r_c <= r_c + 3'd1;
                    end
                end
            end
            ST_CMP: begin
                if (r_dist > r_r) begin
                    r_sep <= 1'b1;
                end else if (r_ax == AXIS_FACE_LAST) begin
                    r_i <= 2'd0;
                    r_j <= 2'd0;
                end else if (r_ax != AXIS_LAST) begin
                    r_ax <= r_ax + 4'd1;
                    if (r_ax >= AXIS_CROSS_FIRST) begin
                        if (r_j == 2'd2) begin
                            r_j <= 2'd0;
                            r_i <= r_i + 2'd1;
                        end else begin
                            r_j <= r_j + 2'd1;
                        end
                    end
                end
            end
            ST_SCA: if (r_rd) r_va <= rv;
            ST_SCB: begin
                if (r_rd) begin
                    r_short <= r_short | eq;
                    if (r_j == 2'd2) begin
                        r_j <= 2'd0;
                        if (r_i == 2'd2) begin
                            r_i  <= 2'd0;
                            r_ax <= AXIS_CROSS_FIRST;
                        end else begin
                            r_i <= r_i + 2'd1;
                        end
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                end
            end
            ST_CRA: if (r_rd) r_va <= rv;
            ST_CRB: begin
                if (r_rd) begin
                    r_vb <= rv;
                    r_c  <= 3'd0;
                end
            end
            ST_CRM: begin
                if (mul_done) begin
                    // even step holds the first product, odd step forms one component
                    if (!r_c[0]) r_tmp <= mul_p;
                    else         r_l[r_c[2:1]] <= sat_sub(r_tmp, mul_p);
                    if (c_last6) begin
                        r_c   <= 3'd0;
                        r_acc <= '0;
                    end else begin
                        r_c <= r_c + 3'd1;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    r_overlap <= !r_sep;
                    r_axis    <= r_sep ? r_ax : AXIS_NONE;
                    r_pshort  <= !r_sep && r_short;
                end
            end
            default: ;
        endcase
    end

    assign i_in.ready              = (r_state == ST_IDLE);
    assign o_res.valid             = r_ovalid;
    assign o_res.overlap           = r_overlap;
    assign o_res.separating_axis   = r_axis;
    assign o_res.parallel_shortcut = r_pshort;
endmodule
`default_nettype wire

// ----- design/obb_sat_mul.sv -----
`default_nettype none
module obb_sat_mul #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire obb_pkg::t_s64 i_a,
    input  wire obb_pkg::t_s64 i_b,
    output logic               o_done,
    output obb_pkg::t_s64      o_p
);
    import obb_pkg::*;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_PP3  = 3'd4;
    localparam logic [2:0] PH_NEG  = 3'd5;
    localparam logic [2:0] PH_SAT  = 3'd6;

    logic [2:0]          r_ph;
    logic [63:0]         r_ua;
    logic [63:0]         r_ub;
    logic                r_neg;
    logic [127:0]        r_acc;
    logic [1:0]          pp_sel;
    logic [63:0]         pp;
    logic [6:0]          pp_sh;
    logic signed [127:0] shifted;
    logic                fits;

    // partial products: low x low, low x high, high x low, high x high
    assign pp_sel  = 2'(r_ph - 3'd1);
    assign pp      = r_ua[32*pp_sel[1] +: 32] * r_ub[32*pp_sel[0] +: 32];
    assign pp_sh   = {2'(pp_sel[1] + pp_sel[0]) , 5'd0};
    assign shifted = $signed(r_acc) >>> FRAC_BITS;
    assign fits    = (&shifted[127:63]) | ~(|shifted[127:63]);

    assign o_done = (r_ph == PH_SAT);
    assign o_p    = fits ? shifted[63:0] : (r_acc[127] ? S64_MIN : S64_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_IDLE;
        end else if (r_ph == PH_IDLE) begin
            if (i_start) begin
                r_ph <= 3'd1;
            end
        end else if (r_ph == PH_SAT) begin
            r_ph <= PH_IDLE;
        end else begin
            r_ph <= r_ph + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ph == PH_IDLE && i_start) begin
            r_ua  <= i_a[63] ? 64'(-i_a) : i_a;
            r_ub  <= i_b[63] ? 64'(-i_b) : i_b;
            r_neg <= i_a[63] ^ i_b[63];
            r_acc <= '0;
        end else if (r_ph != PH_IDLE && r_ph <= PH_PP3) begin
            r_acc <= r_acc + (128'(pp) << pp_sh);
        end else if (r_ph == PH_NEG && r_neg) begin
            r_acc <= -r_acc;
        end
    end
endmodule
`default_nettype wire

// ----- design/obb_vec_store.sv -----
`default_nettype none
module obb_vec_store #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 10
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < DEPTH; n++) begin
                r_mem[n] <= '0;
            end
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read: data appears in the cycle after the address
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- design/obb_chk.sv -----
`default_nettype none
module obb_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_in_evaluate,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic       i_overlap,
    input wire logic [3:0] i_axis,
    input wire logic       i_pshort
);
    import obb_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_overlap) && $stable(i_axis) && $stable(i_pshort))
        else $error("result changed while stalled");

    a_ovl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_overlap == (i_axis == AXIS_NONE)))
        else $error("overlap and axis index disagree");

    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_pshort |-> i_overlap)
        else $error("shortcut without overlap");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_evaluate |=> !i_in_ready)
        else $error("ready after evaluate transaction");
endmodule

bind obb_obb_separating_axis_test obb_chk u_obb_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_evaluate (i_in.evaluate),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_overlap     (o_res.overlap),
    .i_axis        (o_res.separating_axis),
    .i_pshort      (o_res.parallel_shortcut)
);
`default_nettype wire
